### hw/rtl/rth_pkg.sv
// Package with the shared types, constants and the divider step of the RGB to HSV pipeline.
`default_nettype none

package rth_pkg;

  localparam int unsigned CompW = 8;
  localparam int unsigned QuotW = 16;
  localparam int unsigned HueW = 15;
  localparam int unsigned SelW = 11;
  localparam int unsigned NumW = CompW + QuotW;
  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages = QuotW / DivStepsPerStage;

  typedef enum logic [1:0] {
    SelRedPos,
    SelRedNeg,
    SelGreen,
    SelBlue
  } hue_sel_e;

  typedef struct packed {
    logic [CompW-1:0] rem;
    logic [QuotW-1:0] lo;
    logic [CompW-1:0] dv;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        hue;
    div_lane_t        sat;
    logic [CompW-1:0] value;
    logic             eof;
  } div_t;

  // One restoring division step: the remainder stays below the divisor, and the
  // low word shifts out dividend bits and takes in quotient bits.
  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t      res;
    logic [CompW:0] trial;
    logic [CompW:0] diff;
    res   = l;
    trial = {l.rem, l.lo[QuotW-1]};
    diff  = trial - {1'b0, l.dv};
    if (trial >= {1'b0, l.dv}) begin
      res.rem = diff[CompW-1:0];
      res.lo  = {l.lo[QuotW-2:0], 1'b1};
    end else begin
      res.rem = trial[CompW-1:0];
      res.lo  = {l.lo[QuotW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rth_pix_if.sv
// Interface of the input channel that carries one RGB pixel word.
`default_nettype none

interface rth_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       end_of_frame;

  modport source(output valid, output blue, output green, output red,
                 output end_of_frame, input ready);
  modport sink(input valid, input blue, input green, input red,
               input end_of_frame, output ready);
endinterface

`default_nettype wire

### hw/rtl/rth_hsv_if.sv
// Interface of the output channel that carries one HSV word.
`default_nettype none

interface rth_hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [7:0]  value;
  logic        end_of_frame_out;

  modport source(output valid, output hue, output saturation, output value,
                 output end_of_frame_out, input ready);
  modport sink(input valid, input hue, input saturation, input value,
               input end_of_frame_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/rth_div_stage.sv
// One pipeline stage of the two-lane divider, four quotient bits per lane.
`default_nettype none

module rth_div_stage
  import rth_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire div_t data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output div_t      data_o
);

  logic valid_q;
  div_t data_q;
  div_t data_d;

  always_comb begin
    data_d = data_i;
    for (int unsigned i = 0; i < DivStepsPerStage; i++) begin
      data_d.hue = div_step(data_d.hue);
      data_d.sat = div_step(data_d.sat);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### hw/rtl/rgb_to_hsv_pixel.sv
// Top level of the pipelined RGB to HSV pixel converter.
`default_nettype none

// Channel  Dir  Word
// pix_i    in   blue, green, red (8 bits each), end_of_frame
// hsv_o    out  hue (15 bits), saturation (16 bits), value (8 bits), end_of_frame_out
//
// One pixel enters per cycle while the output is not stalled.
// Two stages find max, min and the hue numerator, then four stages each
// resolve four quotient bits of the hue and saturation divisions.
// A stage advances when it is empty or the next one advances, so a stall
// holds every word in place. Reset empties the pipeline.

module rgb_to_hsv_pixel
  import rth_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  rth_pix_if.sink   pix_i,
  rth_hsv_if.source hsv_o
);

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
    logic [CompW-1:0] mx;
    logic [CompW-1:0] dif;
    hue_sel_e         sel;
    logic             eof;
  } st1_t;

  logic             s1_valid_q;
  st1_t             s1_q;
  st1_t             s1_d;
  logic             s1_ready;
  logic [CompW-1:0] mx_ab;
  logic [CompW-1:0] mn_ab;

  logic             s2_valid_q;
  div_t             s2_q;
  div_t             s2_d;
  logic             s2_ready;
  logic [SelW-1:0]  k_w;
  logic [SelW-1:0]  d_w;
  logic [NumW-1:0]  hue_num;
  logic [NumW-1:0]  sat_num;

  logic             dv_valid [DivStages+1];
  logic             dv_ready [DivStages+1];
  div_t             dv_data  [DivStages+1];

  // Stage one: largest, smallest and which component leads.
  always_comb begin
    mx_ab = (pix_i.blue > pix_i.green) ? pix_i.blue : pix_i.green;
    mn_ab = (pix_i.blue < pix_i.green) ? pix_i.blue : pix_i.green;
    s1_d.red   = pix_i.red;
    s1_d.green = pix_i.green;
    s1_d.blue  = pix_i.blue;
    s1_d.mx    = (mx_ab > pix_i.red) ? mx_ab : pix_i.red;
    s1_d.dif   = s1_d.mx - ((mn_ab < pix_i.red) ? mn_ab : pix_i.red);
    s1_d.eof   = pix_i.end_of_frame;
    if (pix_i.red == s1_d.mx) begin
      s1_d.sel = (pix_i.green >= pix_i.blue) ? SelRedPos : SelRedNeg;
    end else if (pix_i.green == s1_d.mx) begin
      s1_d.sel = SelGreen;
    end else begin
      s1_d.sel = SelBlue;
    end
  end

  assign s1_ready    = !s1_valid_q || s2_ready;
  assign pix_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && s1_ready) begin
      s1_q <= s1_d;
    end
  end

  // Stage two: numerators of both divisions; a zero divisor becomes one so the
  // quotient comes out zero.
  always_comb begin
    d_w = {{(SelW-CompW){1'b0}}, s1_q.dif};
    unique case (s1_q.sel)
      SelRedPos: k_w = {{(SelW-CompW){1'b0}}, s1_q.green}
                       - {{(SelW-CompW){1'b0}}, s1_q.blue};
      SelRedNeg: k_w = (d_w << 2) + (d_w << 1) + {{(SelW-CompW){1'b0}}, s1_q.green}
                       - {{(SelW-CompW){1'b0}}, s1_q.blue};
      SelGreen:  k_w = (d_w << 1) + {{(SelW-CompW){1'b0}}, s1_q.blue}
                       - {{(SelW-CompW){1'b0}}, s1_q.red};
      SelBlue:   k_w = (d_w << 2) + {{(SelW-CompW){1'b0}}, s1_q.red}
                       - {{(SelW-CompW){1'b0}}, s1_q.green};
      default:   k_w = '0;
    endcase
    hue_num = ({{(NumW-SelW){1'b0}}, k_w} << 12) - ({{(NumW-SelW){1'b0}}, k_w} << 8);
    sat_num = ({{(NumW-CompW){1'b0}}, s1_q.dif} << QuotW)
              - {{(NumW-CompW){1'b0}}, s1_q.dif};
    s2_d.hue.rem = hue_num[NumW-1:QuotW];
    s2_d.hue.lo  = hue_num[QuotW-1:0];
    s2_d.hue.dv  = (s1_q.dif == '0) ? CompW'(1) : s1_q.dif;
    s2_d.sat.rem = sat_num[NumW-1:QuotW];
    s2_d.sat.lo  = sat_num[QuotW-1:0];
    s2_d.sat.dv  = (s1_q.mx == '0) ? CompW'(1) : s1_q.mx;
    s2_d.value   = s1_q.mx;
    s2_d.eof     = s1_q.eof;
  end

  assign s2_ready = !s2_valid_q || dv_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_q <= s2_d;
    end
  end

  assign dv_valid[0] = s2_valid_q;
  assign dv_data[0]  = s2_q;

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    rth_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv_valid[s]),
      .ready_o(dv_ready[s]),
      .data_i (dv_data[s]),
      .valid_o(dv_valid[s+1]),
      .ready_i(dv_ready[s+1]),
      .data_o (dv_data[s+1])
    );
  end

  assign dv_ready[DivStages]    = hsv_o.ready;
  assign hsv_o.valid            = dv_valid[DivStages];
  assign hsv_o.hue              = dv_data[DivStages].hue.lo[HueW-1:0];
  assign hsv_o.saturation       = dv_data[DivStages].sat.lo;
  assign hsv_o.value            = dv_data[DivStages].value;
  assign hsv_o.end_of_frame_out = dv_data[DivStages].eof;

endmodule

`default_nettype wire
